// File: hdl/energy_voice_activity_gate_unit_macros.svh
// Assertion macros used by the checker file of the voice activity gate.
`ifndef ENERGY_VOICE_ACTIVITY_GATE_UNIT_MACROS_SVH
`define ENERGY_VOICE_ACTIVITY_GATE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EVAG_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define EVAG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/evag_pkg.sv
// Types and constants shared by the energy voice activity gate files.
package evag_pkg;

  // Field widths.
  localparam int SAMPLE_W  = 16;
  localparam int LEVEL_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_W     = 13;
  localparam int MINLVL_W  = 15;
  localparam int RUN_W     = 16;

  // Buffer and history sizing.
  localparam int MAX_BUFFER  = 4096;
  localparam int HIST_DEPTH  = 15;
  localparam int SLOT_W      = $clog2(HIST_DEPTH);
  localparam int LEVEL_MAX   = 32768;
  localparam int TOTAL_W     = $clog2(LEVEL_MAX * HIST_DEPTH + 1);
  localparam int ACC_W       = 28;
  localparam int DIV_CNT_W   = $clog2(ACC_W);

  // Reciprocal of the history depth. Multiplying the history total by it and
  // dropping the low SMOOTH_SHIFT bits gives the exact floor of the mean.
  localparam int SMOOTH_SHIFT = 24;
  localparam int SMOOTH_MUL   = (2 ** SMOOTH_SHIFT + HIST_DEPTH - 1) / HIST_DEPTH;
  localparam int SMOOTH_MUL_W = $clog2(SMOOTH_MUL + 1);

  // Register reset values.
  localparam int RST_BUFFER_LENGTH = 256;
  localparam int RST_MIN_LEVEL     = 983;
  localparam int RST_MIN_ACTIVE    = 20;
  localparam int RST_MIN_INACTIVE  = 100;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_LENGTH,
    CFG_MIN_LEVEL,
    CFG_MIN_ACTIVE,
    CFG_MIN_INACTIVE
  } evag_cfg_t;

  // Recording events reported with each buffer status.
  typedef enum logic [1:0] {
    EV_NONE,
    EV_START,
    EV_DISPOSE,
    EV_SAVE
  } evag_event_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_ACC,
    ST_DIV_MEAN,
    ST_UPDATE,
    ST_DIV_SMOOTH,
    ST_EMIT
  } evag_state_t;

endpackage

// File: hdl/evag_sample_if.sv
// Sample and status channels of the voice activity gate.
interface evag_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [evag_pkg::SAMPLE_W-1:0]   left_sample;

  modport source (output valid, output left_sample, input ready);
  modport sink (input valid, input left_sample, output ready);
endinterface

interface evag_status_if;
  logic                                valid;
  logic                                ready;
  logic [evag_pkg::LEVEL_W-1:0]        smoothed_level;
  logic                                recording_on;
  logic                                awaiting_confirm;
  logic [1:0]                          event_code;

  modport source (output valid, output smoothed_level, output recording_on,
                  output awaiting_confirm, output event_code, input ready);
  modport sink (input valid, input smoothed_level, input recording_on,
                input awaiting_confirm, input event_code, output ready);
endinterface

// File: hdl/evag_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module evag_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/energy_voice_activity_gate_unit.sv
// Energy voice activity gate: takes Q15 samples, emits one status per buffer end.
//
// A sample that does not close a buffer is added to the accumulator and the
// unit stays ready for the next one. The sample that closes a buffer starts a
// closing sequence (its acceptance, division for the buffer mean, history
// update, smoothed level, load of the status register), which also waits while
// the previous status has not been taken; no further sample is accepted during
// that sequence. The buffer mean comes from a restoring divider, one quotient
// bit per cycle over the 28-bit accumulator; the smoothed level is a single
// multiplication of the history total by the reciprocal of the history depth.
// The 15-entry level history lives in a RAM with registered read; per-entry
// valid bits cleared at reset make unwritten entries read as zero.
module energy_voice_activity_gate_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [evag_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [evag_pkg::CFG_W-1:0]          cfg_data,
  evag_sample_if.sink                         sample_in,
  evag_status_if.source                       status_out
);

  localparam int LW  = evag_pkg::LEN_W;
  localparam int AW  = evag_pkg::ACC_W;
  localparam int TW  = evag_pkg::TOTAL_W;
  localparam int SW  = evag_pkg::SLOT_W;
  localparam int VW  = evag_pkg::LEVEL_W;
  localparam int RW  = evag_pkg::RUN_W;
  localparam int CW  = evag_pkg::DIV_CNT_W;
  localparam int PW  = evag_pkg::TOTAL_W + evag_pkg::SMOOTH_MUL_W;
  localparam int SAMPLE_EXT_W = evag_pkg::SAMPLE_W + 1;

  // Configuration registers.
  logic [LW-1:0]                   buffer_length;
  logic [evag_pkg::MINLVL_W-1:0]   min_level;
  logic [RW-1:0]                   min_active_buffers;
  logic [RW-1:0]                   min_inactive_buffers;

  // Buffer and history state.
  logic [AW-1:0]                   level_acc;
  logic [LW-1:0]                   sample_pos;
  logic [TW-1:0]                   history_total;
  logic [SW-1:0]                   history_slot;
  logic [evag_pkg::HIST_DEPTH-1:0] hist_valid;
  logic [RW-1:0]                   loud_run;
  logic [RW-1:0]                   quiet_run;
  logic                            is_recording;
  logic                            is_awaiting;
  evag_pkg::evag_event_t           event_reg;

  // Mean divider registers.
  logic [AW-1:0]                   div_q;
  logic [LW-1:0]                   div_rem;
  logic [LW-1:0]                   div_den;
  logic [CW-1:0]                   div_cnt;

  // Output register.
  logic                            out_valid;
  logic [VW-1:0]                   out_level;
  logic                            out_rec;
  logic                            out_await;
  evag_pkg::evag_event_t           out_event;

  evag_pkg::evag_state_t           state;
  evag_pkg::evag_state_t           state_next;

  // History RAM.
  logic [VW-1:0]                   ram_rdata;
  logic                            ram_we;

  // Combinational datapath values.
  logic [LW-1:0]                   len_eff;
  logic [SAMPLE_EXT_W-1:0]         mag;
  logic [SAMPLE_EXT_W-1:0]         sample_ext;
  logic [AW-1:0]                   acc_sum;
  logic [LW-1:0]                   pos_inc;
  logic                            buffer_close;
  logic                            sample_xfer;
  logic                            out_free;
  logic                            div_last;
  logic [LW:0]                     rem_shift;
  logic                            rem_fits;
  logic [LW-1:0]                   rem_step;
  logic [VW-1:0]                   mean;
  logic [VW-1:0]                   old_level;
  logic [TW-1:0]                   total_next;
  logic [TW-1:0]                   level_limit;
  logic [PW-1:0]                   smooth_prod;
  logic [VW-1:0]                   smooth_level;
  logic                            loud;
  logic                            active;
  logic                            inactive;
  logic [RW-1:0]                   loud_next;
  logic [RW-1:0]                   quiet_next;
  logic                            rec_next;
  logic                            await_next;
  evag_pkg::evag_event_t           event_next;

  evag_ram #(
    .WIDTH (VW),
    .DEPTH (evag_pkg::HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (history_slot),
    .wdata (mean),
    .raddr (history_slot),
    .rdata (ram_rdata)
  );

  // Effective buffer length: zero acts as one, large values clamp.
  always_comb begin
    if (buffer_length == '0) begin
      len_eff = LW'(1);
    end else if (buffer_length > LW'(evag_pkg::MAX_BUFFER)) begin
      len_eff = LW'(evag_pkg::MAX_BUFFER);
    end else begin
      len_eff = buffer_length;
    end
  end

  // Sample magnitude; the most negative sample gives 32768.
  assign sample_ext   = {sample_in.left_sample[evag_pkg::SAMPLE_W-1], sample_in.left_sample};
  assign mag          = sample_ext[SAMPLE_EXT_W-1] ? (SAMPLE_EXT_W'(0) - sample_ext) : sample_ext;
  assign acc_sum      = level_acc + AW'(mag);
  assign pos_inc      = sample_pos + LW'(1);
  assign buffer_close = (pos_inc >= len_eff);
  assign sample_xfer  = sample_in.valid && sample_in.ready;
  assign out_free     = !out_valid || status_out.ready;

  // One restoring division step per cycle; the quotient shifts into div_q.
  assign rem_shift = {div_rem, div_q[AW-1]};
  assign rem_fits  = (rem_shift >= {1'b0, div_den});
  assign rem_step  = rem_fits ? LW'(rem_shift - {1'b0, div_den}) : LW'(rem_shift);
  assign div_last  = (div_cnt == CW'(AW - 1));

  // Buffer mean clamp and history total update. The history entry was read
  // at the closing transfer and the slot does not move until this update,
  // so the registered read data already belongs to the current slot.
  assign mean        = (div_q > AW'(evag_pkg::LEVEL_MAX)) ? VW'(evag_pkg::LEVEL_MAX)
                                                          : div_q[VW-1:0];
  assign old_level   = hist_valid[history_slot] ? ram_rdata : '0;
  assign total_next  = history_total - TW'(old_level) + TW'(mean);
  assign level_limit = TW'(min_level) * TW'(evag_pkg::HIST_DEPTH);
  assign loud        = (total_next > level_limit);
  assign ram_we      = (state == evag_pkg::ST_UPDATE);

  // Smoothed level from the registered history total by reciprocal multiply.
  assign smooth_prod  = PW'(history_total) * PW'(evag_pkg::SMOOTH_MUL);
  assign smooth_level = smooth_prod[evag_pkg::SMOOTH_SHIFT +: VW];

  // Run counters and the recording state machine for one closed buffer.
  always_comb begin
    loud_next  = loud_run;
    quiet_next = quiet_run;
    rec_next   = is_recording;
    await_next = is_awaiting;
    event_next = evag_pkg::EV_NONE;
    if (loud) begin
      loud_next  = (loud_run == '1) ? loud_run : loud_run + RW'(1);
      quiet_next = '0;
      if (!is_recording) begin
        rec_next   = 1'b1;
        await_next = 1'b1;
        event_next = evag_pkg::EV_START;
      end
    end else begin
      quiet_next = (quiet_run == '1) ? quiet_run : quiet_run + RW'(1);
      loud_next  = '0;
    end
    active   = (loud_next > min_active_buffers);
    inactive = (quiet_next > min_inactive_buffers);
    if (rec_next) begin
      if (await_next) begin
        if (inactive) begin
          rec_next   = 1'b0;
          await_next = 1'b0;
          event_next = evag_pkg::EV_DISPOSE;
        end
        if (active) begin
          await_next = 1'b0;
        end
      end else if (inactive) begin
        rec_next   = 1'b0;
        await_next = 1'b0;
        event_next = evag_pkg::EV_SAVE;
      end
    end
  end

  // Sequencer next state and input ready.
  always_comb begin
    state_next      = state;
    sample_in.ready = 1'b0;
    case (state)
      evag_pkg::ST_ACC: begin
        sample_in.ready = 1'b1;
        if (sample_in.valid && buffer_close) begin
          state_next = evag_pkg::ST_DIV_MEAN;
        end
      end
      evag_pkg::ST_DIV_MEAN: begin
        if (div_last) begin
          state_next = evag_pkg::ST_UPDATE;
        end
      end
      evag_pkg::ST_UPDATE: begin
        state_next = evag_pkg::ST_DIV_SMOOTH;
      end
      evag_pkg::ST_DIV_SMOOTH: begin
        state_next = evag_pkg::ST_EMIT;
      end
      evag_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = evag_pkg::ST_ACC;
        end
      end
      default: begin
        state_next = evag_pkg::ST_ACC;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= evag_pkg::ST_ACC;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; an index outside the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length        <= LW'(evag_pkg::RST_BUFFER_LENGTH);
      min_level            <= evag_pkg::MINLVL_W'(evag_pkg::RST_MIN_LEVEL);
      min_active_buffers   <= RW'(evag_pkg::RST_MIN_ACTIVE);
      min_inactive_buffers <= RW'(evag_pkg::RST_MIN_INACTIVE);
    end else if (cfg_we) begin
      case (evag_pkg::evag_cfg_t'(cfg_index))
        evag_pkg::CFG_BUFFER_LENGTH: buffer_length        <= cfg_data[LW-1:0];
        evag_pkg::CFG_MIN_LEVEL:     min_level            <= cfg_data[evag_pkg::MINLVL_W-1:0];
        evag_pkg::CFG_MIN_ACTIVE:    min_active_buffers   <= cfg_data[RW-1:0];
        evag_pkg::CFG_MIN_INACTIVE:  min_inactive_buffers <= cfg_data[RW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Accumulation, history and recording state.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_acc     <= '0;
      sample_pos    <= '0;
      history_total <= '0;
      history_slot  <= '0;
      hist_valid    <= '0;
      loud_run      <= '0;
      quiet_run     <= '0;
      is_recording  <= 1'b0;
      is_awaiting   <= 1'b0;
    end else begin
      if (state == evag_pkg::ST_ACC && sample_xfer) begin
        if (buffer_close) begin
          level_acc  <= '0;
          sample_pos <= '0;
        end else begin
          level_acc  <= acc_sum;
          sample_pos <= pos_inc;
        end
      end
      if (state == evag_pkg::ST_UPDATE) begin
        history_total              <= total_next;
        hist_valid[history_slot]   <= 1'b1;
        history_slot <= (history_slot == SW'(evag_pkg::HIST_DEPTH - 1)) ? '0
                                                                       : history_slot + SW'(1);
        loud_run     <= loud_next;
        quiet_run    <= quiet_next;
        is_recording <= rec_next;
        is_awaiting  <= await_next;
      end
    end
  end

  // Mean divider and event latch; div_q then carries the smoothed level to the output.
  always_ff @(posedge clk) begin
    case (state)
      evag_pkg::ST_ACC: begin
        div_q   <= acc_sum;
        div_den <= len_eff;
        div_rem <= '0;
        div_cnt <= '0;
      end
      evag_pkg::ST_DIV_MEAN: begin
        div_q   <= {div_q[AW-2:0], rem_fits};
        div_rem <= rem_step;
        div_cnt <= div_cnt + CW'(1);
      end
      evag_pkg::ST_UPDATE: begin
        event_reg <= event_next;
      end
      evag_pkg::ST_DIV_SMOOTH: begin
        div_q <= AW'(smooth_level);
      end
      default: begin
      end
    endcase
  end

  // Status output register; a new status loads only once the old one is gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == evag_pkg::ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (status_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == evag_pkg::ST_EMIT && out_free) begin
      out_level <= div_q[VW-1:0];
      out_rec   <= is_recording;
      out_await <= is_awaiting;
      out_event <= event_reg;
    end
  end

  assign status_out.valid            = out_valid;
  assign status_out.smoothed_level   = out_level;
  assign status_out.recording_on     = out_rec;
  assign status_out.awaiting_confirm = out_await;
  assign status_out.event_code       = out_event;

endmodule

// File: hdl/evag_checker.sv
// Port-level checker for the voice activity gate, bound to the top level.
`include "energy_voice_activity_gate_unit_macros.svh"

module evag_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [evag_pkg::LEVEL_W-1:0]  smoothed_level,
  input logic                          recording_on,
  input logic                          awaiting_confirm,
  input logic [1:0]                    event_code
);

  // A stalled status transfer keeps its contents.
  `EVAG_ASSERT_NEXT(a_status_held, clk, rst, out_valid && !out_ready, out_valid && $stable(smoothed_level) && $stable(event_code) && $stable(recording_on) && $stable(awaiting_confirm), "status changed while stalled")

  // A start leaves a recording running; it may already be confirmed.
  `EVAG_ASSERT_IMPLIES(a_start_flags, clk, rst, out_valid && event_code == evag_pkg::EV_START, recording_on, "start without a running recording")

  // A dispose or save ends the recording.
  `EVAG_ASSERT_IMPLIES(a_end_flags, clk, rst, out_valid && (event_code == evag_pkg::EV_DISPOSE || event_code == evag_pkg::EV_SAVE), !recording_on && !awaiting_confirm, "recording still on after end event")

  // The smoothed level never exceeds full scale, and no wait without a recording.
  `EVAG_ASSERT_IMPLIES(a_level_range, clk, rst, out_valid, smoothed_level <= evag_pkg::LEVEL_W'(evag_pkg::LEVEL_MAX) && (recording_on || !awaiting_confirm), "status out of range")

endmodule

bind energy_voice_activity_gate_unit evag_checker u_evag_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (status_out.valid),
  .out_ready        (status_out.ready),
  .smoothed_level   (status_out.smoothed_level),
  .recording_on     (status_out.recording_on),
  .awaiting_confirm (status_out.awaiting_confirm),
  .event_code       (status_out.event_code)
);
